/* hdl/sdsf_pkg.sv */
// shared constants, types and segment lookup for the signed four-digit segment formatter
`timescale 1ns / 1ps

package sdsf_pkg;

	localparam int unsigned DIGITS = 4;

	localparam logic [15:0] DISP_LIMIT  = 16'd9999;
	localparam logic [15:0] SCALE_LIMIT = 16'd999;
	localparam logic [15:0] RADIX       = 16'd10;

	// reciprocal multipliers, exact for magnitudes up to 32768
	localparam logic [33:0] RECIP_10    = 34'd52429;
	localparam int unsigned SHIFT_10    = 19;
	localparam logic [33:0] RECIP_100   = 34'd41944;
	localparam int unsigned SHIFT_100   = 22;
	localparam logic [33:0] RECIP_1000  = 34'd67109;
	localparam int unsigned SHIFT_1000  = 26;
	localparam logic [33:0] RECIP_10000 = 34'd13422;
	localparam int unsigned SHIFT_10000 = 27;

	localparam logic [7:0] MINUS_PATTERN = 8'h40;
	localparam logic [7:0] POINT_BIT     = 8'h80;

	typedef logic [3:0] bcd_digit_t;
	typedef logic [7:0] segments_t;

	function automatic segments_t digit_pattern(bcd_digit_t d);
		segments_t p;
		unique case (d)
			4'd0: p = 8'h3F;
			4'd1: p = 8'h06;
			4'd2: p = 8'h5B;
			4'd3: p = 8'h4F;
			4'd4: p = 8'h66;
			4'd5: p = 8'h6D;
			4'd6: p = 8'h7D;
			4'd7: p = 8'h07;
			4'd8: p = 8'h7F;
			4'd9: p = 8'h6F;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

/* hdl/sdsf_sample_if.sv */
// input channel: signed value and decimal point position
`timescale 1ns / 1ps

interface sdsf_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] value;
	logic [2:0]  point_position;

	modport source (output valid, output value, output point_position, input ready);
	modport sink   (input valid, input value, input point_position, output ready);
endinterface

/* hdl/sdsf_display_if.sv */
// output channel: four segment patterns, lit mask and shown flag
`timescale 1ns / 1ps

interface sdsf_display_if;
	logic       valid;
	logic       ready;
	logic [7:0] digit0_segments;
	logic [7:0] digit1_segments;
	logic [7:0] digit2_segments;
	logic [7:0] digit3_segments;
	logic [3:0] digits_lit;
	logic       shown;

	modport source (output valid, output digit0_segments, output digit1_segments,
		output digit2_segments, output digit3_segments, output digits_lit,
		output shown, input ready);
	modport sink   (input valid, input digit0_segments, input digit1_segments,
		input digit2_segments, input digit3_segments, input digits_lit,
		input shown, output ready);
endinterface

/* hdl/signed_four_digit_segment_formatter_core.sv */
// signed four-digit seven-segment formatter, input register then result register
//
//   channel   dir  payload                                        transaction
//   sample    in   value[15:0] signed, point_position[2:0]        valid & ready
//   display   out  digit0..3_segments[7:0], digits_lit, shown     valid & ready
//
// one transaction per cycle sustained while display.ready holds; a sample reaches display
// through the two-register pipe: input register, conversion, result register
// digits come from parallel constant-reciprocal multiplies of the magnitude
// arst_n clears both valid flags; payload registers are not reset
// a stalled display holds its result and the input register still takes one more sample
`timescale 1ns / 1ps

module signed_four_digit_segment_formatter_core (
	input  logic                  clk,
	input  logic                  arst_n,
	sdsf_sample_if.sink           sample,
	sdsf_display_if.source        display
);

	logic        v_s1;
	logic [15:0] value_s1;
	logic [2:0]  point_s1;

	logic        v_s2;
	logic [7:0]  seg_s2 [sdsf_pkg::DIGITS];
	logic [3:0]  lit_s2;
	logic        shown_s2;

	logic        adv;

	assign adv          = !v_s2 || display.ready;
	assign sample.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			value_s1 <= sample.value;
			point_s1 <= sample.point_position;
		end
	end

	// conversion
	logic                  negative;
	logic [15:0]           mag;
	logic [33:0]           prod10, prod100, prod1000, prod10000;
	logic [11:0]           q1;
	logic [8:0]            q2;
	logic [5:0]            q3;
	logic [1:0]            q4;
	sdsf_pkg::bcd_digit_t  r0, r1, r2, r3, r4;
	logic                  scale;
	logic                  shown_c;
	sdsf_pkg::bcd_digit_t  dig [sdsf_pkg::DIGITS];
	logic [1:0]            top;
	logic [2:0]            pt;
	logic [7:0]            seg_c [sdsf_pkg::DIGITS];
	logic [3:0]            lit_c;

	always_comb begin
		negative  = value_s1[15];
		mag       = negative ? 16'(~value_s1 + 16'd1) : value_s1;

		prod10    = 34'(mag) * sdsf_pkg::RECIP_10;
		prod100   = 34'(mag) * sdsf_pkg::RECIP_100;
		prod1000  = 34'(mag) * sdsf_pkg::RECIP_1000;
		prod10000 = 34'(mag) * sdsf_pkg::RECIP_10000;
		q1 = 12'(prod10 >> sdsf_pkg::SHIFT_10);
		q2 = 9'(prod100 >> sdsf_pkg::SHIFT_100);
		q3 = 6'(prod1000 >> sdsf_pkg::SHIFT_1000);
		q4 = 2'(prod10000 >> sdsf_pkg::SHIFT_10000);

		r0 = 4'(mag - 16'(q1) * sdsf_pkg::RADIX);
		r1 = 4'(q1 - 12'(q2) * 12'(sdsf_pkg::RADIX));
		r2 = 4'(q2 - 9'(q3) * 9'(sdsf_pkg::RADIX));
		r3 = 4'(q3 - 6'(q4) * 6'(sdsf_pkg::RADIX));
		r4 = {2'b00, q4};

		// large negative drops its last digit
		scale   = negative && (mag > sdsf_pkg::SCALE_LIMIT);
		shown_c = negative || (mag <= sdsf_pkg::DISP_LIMIT);

		if (scale) begin
			dig[0] = r1;
			dig[1] = r2;
			dig[2] = r3;
			dig[3] = r4;
		end else begin
			dig[0] = r0;
			dig[1] = r1;
			dig[2] = r2;
			dig[3] = r3;
		end

		if (dig[3] != 4'd0) begin
			top = 2'd3;
		end else if (dig[2] != 4'd0) begin
			top = 2'd2;
		end else if (dig[1] != 4'd0) begin
			top = 2'd1;
		end else begin
			top = 2'd0;
		end

		pt = (scale && point_s1 != 3'd0) ? 3'(point_s1 - 3'd1) : point_s1;

		for (int k = 0; k < sdsf_pkg::DIGITS; k++) begin
			if (!shown_c) begin
				seg_c[k] = 8'h00;
				lit_c[k] = 1'b0;
			end else if (3'(k) <= {1'b0, top}) begin
				seg_c[k] = sdsf_pkg::digit_pattern(dig[k])
					| ((pt == 3'(k)) ? sdsf_pkg::POINT_BIT : 8'h00);
				lit_c[k] = 1'b1;
			end else if (negative && 3'(k) == 3'({1'b0, top} + 3'd1)) begin
				seg_c[k] = sdsf_pkg::MINUS_PATTERN;
				lit_c[k] = 1'b1;
			end else begin
				seg_c[k] = 8'h00;
				lit_c[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			seg_s2   <= seg_c;
			lit_s2   <= lit_c;
			shown_s2 <= shown_c;
		end
	end

	assign display.valid           = v_s2;
	assign display.digit0_segments = seg_s2[0];
	assign display.digit1_segments = seg_s2[1];
	assign display.digit2_segments = seg_s2[2];
	assign display.digit3_segments = seg_s2[3];
	assign display.digits_lit      = lit_s2;
	assign display.shown           = shown_s2;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> v_s1)
		else $error("accepted sample did not reach input register");

	a_stall_keeps_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(value_s1) && $stable(point_s1)))
		else $error("input register lost a sample during stall");

	a_lit_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (lit_s2 == 4'h0 || lit_s2 == 4'h1 || lit_s2 == 4'h3
			|| lit_s2 == 4'h7 || lit_s2 == 4'hF))
		else $error("lit positions not contiguous from the right");

	a_shown_matches_lit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (shown_s2 == lit_s2[0]))
		else $error("shown flag disagrees with rightmost lit position");

	a_single_point: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $onehot0({seg_s2[3][7], seg_s2[2][7], seg_s2[1][7], seg_s2[0][7]}))
		else $error("more than one decimal point lit");

endmodule
